/* design/sparse_row_matrix_store_core_assert.svh */
// Assertion macros shared by the sparse row matrix store RTL.
`ifndef SPARSE_ROW_MATRIX_STORE_CORE_ASSERT_SVH
`define SPARSE_ROW_MATRIX_STORE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SRMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define SRMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define SRMS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SRMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/srms_pkg.sv */
// Shared types and constants of the sparse row matrix store.
package srms_pkg;

   localparam int COL_W        = 6;
   localparam int ROW_IN_W     = 6;
   localparam int FIELD_VAL_W  = 32;
   localparam int CFG_W        = 7;
   localparam int CSR_IDX_W    = 1;
   localparam int REQ_TDATA_W  = 48;
   localparam int REQ_TUSER_W  = 1;
   localparam int RSP_TDATA_W  = 32;
   localparam int RSP_TUSER_W  = 2;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_IN_USE    = 1'b0,
      CSR_COLUMNS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_COUNT,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_POST,
      ST_UPDATE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DEC
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic check;
      logic load_count;
      logic scan_read;
      logic scan_next;
      logic latch_hit;
      logic post;
      logic upd_write;
      logic sh_init;
      logic sh_read;
      logic sh_write;
      logic ins_write;
      logic dl_init;
      logic dl_read;
      logic dl_write;
      logic cnt_dec;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic oor;
      logic is_write;
      logic wval_zero;
      logic found;
      logic col_less;
      logic col_equal;
      logic pos_at_count;
      logic row_full;
      logic idx_at_pos;
      logic idx_last;
      logic rsp_free;
   } status_type;

endpackage

/* design/srms_ram.sv */
// Generic single write port, single read port RAM with registered read.
module srms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic                                          re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/srms_ctrl.sv */
// Sequencer of the sparse row matrix store: clear, lookup, response, update, insert shift, delete shift.
module srms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  srms_pkg::status_type status,
   output srms_pkg::cmd_type    cmd
);

   import srms_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.oor ? ST_POST : ST_COUNT;
         end
         ST_COUNT: begin
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = status.pos_at_count ? ST_POST : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = status.col_less ? ST_SCAN_RD : ST_POST;
         end
         ST_POST: begin
            if (status.rsp_free) begin
               priority if (status.oor || !status.is_write) begin
                  state_in = ST_IDLE;
               end else if (!status.wval_zero) begin
                  priority if (status.found) state_in = ST_UPDATE;
                  else if (status.row_full) state_in = ST_IDLE;
                  else state_in = ST_SHIFT_RD;
               end else begin
                  state_in = status.found ? ST_DEL_RD : ST_IDLE;
               end
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_SHIFT_RD: begin
            state_in = status.idx_at_pos ? ST_INSERT : ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_RD;
         end
         ST_INSERT: begin
            state_in = ST_IDLE;
         end
         ST_DEL_RD: begin
            state_in = status.idx_last ? ST_DEC : ST_DEL_WR;
         end
         ST_DEL_WR: begin
            state_in = ST_DEL_RD;
         end
         ST_DEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_COUNT: begin
            cmd.load_count = 1'b1;
         end
         ST_SCAN_RD: begin
            cmd.scan_read = !status.pos_at_count;
         end
         ST_SCAN_CMP: begin
            cmd.scan_next = status.col_less;
            cmd.latch_hit = !status.col_less;
         end
         ST_POST: begin
            cmd.post = status.rsp_free;
            // prime the shift index together with the response
            cmd.sh_init = status.rsp_free && !status.oor && status.is_write &&
                          !status.wval_zero && !status.found && !status.row_full;
            cmd.dl_init = status.rsp_free && !status.oor && status.is_write &&
                          status.wval_zero && status.found;
         end
         ST_UPDATE: begin
            cmd.upd_write = 1'b1;
         end
         ST_SHIFT_RD: begin
            cmd.sh_read = !status.idx_at_pos;
         end
         ST_SHIFT_WR: begin
            cmd.sh_write = 1'b1;
         end
         ST_INSERT: begin
            cmd.ins_write = 1'b1;
         end
         ST_DEL_RD: begin
            cmd.dl_read = !status.idx_last;
         end
         ST_DEL_WR: begin
            cmd.dl_write = 1'b1;
         end
         ST_DEC: begin
            cmd.cnt_dec = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* design/srms_dp.sv */
// Datapath of the sparse row matrix store: entry and count RAMs, indexes, output word.
module srms_dp #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [srms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srms_pkg::CFG_W-1:0]        csr_wdata,
   input  logic [srms_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [srms_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [srms_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [srms_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  srms_pkg::cmd_type                 cmd,
   output srms_pkg::status_type              status
);

   import srms_pkg::*;

   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
   localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = COL_W + VALUE_WIDTH;

   // config
   logic [CFG_W-1:0] rows_ff, rows_in, cols_ff, cols_in;

   // captured word
   logic                   op_ff;
   logic [ROW_IN_W-1:0]    row_ff;
   logic [COL_W-1:0]       col_ff;
   logic [VALUE_WIDTH-1:0] wval_ff;
   logic [63:0]            req_value_wide;

   // lookup and shift state
   logic [ADDR_W-1:0]      base_ff;
   logic [CNT_W-1:0]       count_ff, pos_ff, idx_ff;
   logic                   found_ff;
   logic [VALUE_WIDTH-1:0] old_ff;
   logic [ROW_W-1:0]       clr_idx_ff;

   // output word
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   rsp_found_ff, rsp_status_ff;

   logic                   oor;
   logic [ROW_W-1:0]       row_addr;
   logic [CNT_W-1:0]       idx_up, idx_dn, cnt_up, cnt_dn;
   logic [63:0]            old_wide;

   logic                   e_we, e_re;
   logic [ADDR_W-1:0]      e_waddr, e_raddr;
   logic [ENTRY_W-1:0]     e_wdata, e_rdata;
   logic [COL_W-1:0]       rd_col;
   logic [VALUE_WIDTH-1:0] rd_val;

   logic                   c_we, c_re;
   logic [ROW_W-1:0]       c_waddr;
   logic [CNT_W-1:0]       c_wdata, c_rdata;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE:    rows_in = csr_wdata;
            CSR_COLUMNS_IN_USE: cols_in = csr_wdata;
            default:            rows_in = rows_ff;
         endcase
      end
   end

   assign req_value_wide = 64'(req_tdata[12 +: FIELD_VAL_W]);

   // a register above the build limit acts as the limit
   assign oor = !(({1'b0, row_ff} < rows_ff) && (32'(row_ff) < MAX_ROWS) &&
                  ({1'b0, col_ff} < cols_ff) && (32'(col_ff) < MAX_COLUMNS));

   assign row_addr = ROW_W'(row_ff);
   assign idx_up   = idx_ff + CNT_W'(1);
   assign idx_dn   = idx_ff - CNT_W'(1);
   assign cnt_up   = count_ff + CNT_W'(1);
   assign cnt_dn   = count_ff - CNT_W'(1);
   assign old_wide = 64'(old_ff);
   assign rd_col   = e_rdata[ENTRY_W-1 -: COL_W];
   assign rd_val   = e_rdata[VALUE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= CFG_RESET;
         cols_ff      <= CFG_RESET;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         if (cmd.clr_step) clr_idx_ff <= clr_idx_ff + ROW_W'(1);
         if (cmd.post) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_tuser[0];
         row_ff  <= req_tdata[0 +: ROW_IN_W];
         col_ff  <= req_tdata[ROW_IN_W +: COL_W];
         wval_ff <= req_value_wide[VALUE_WIDTH-1:0];
      end
      if (cmd.check) base_ff <= ADDR_W'(32'(row_addr) * MAX_COLUMNS);
      if (cmd.load_count) begin
         count_ff <= c_rdata;
         pos_ff   <= '0;
         found_ff <= 1'b0;
         old_ff   <= '0;
      end
      if (cmd.scan_next) pos_ff <= pos_ff + CNT_W'(1);
      if (cmd.latch_hit) begin
         found_ff <= (rd_col == col_ff);
         old_ff   <= (rd_col == col_ff) ? rd_val : '0;
      end
      if (cmd.sh_init) idx_ff <= count_ff;
      if (cmd.dl_init) idx_ff <= pos_ff;
      if (cmd.sh_write) idx_ff <= idx_dn;
      if (cmd.dl_write) idx_ff <= idx_up;
      if (cmd.post) begin
         rsp_data_ff   <= oor ? '0 : old_wide[RSP_TDATA_W-1:0];
         rsp_found_ff  <= !oor && found_ff;
         rsp_status_ff <= oor;
      end
   end

   // entry RAM: row r owns slots r*MAX_COLUMNS onward
   assign e_re = cmd.scan_read || cmd.sh_read || cmd.dl_read;
   always_comb begin
      priority if (cmd.sh_read) e_raddr = base_ff + ADDR_W'(idx_dn);
      else if (cmd.dl_read)     e_raddr = base_ff + ADDR_W'(idx_up);
      else                      e_raddr = base_ff + ADDR_W'(pos_ff);
   end

   assign e_we    = cmd.upd_write || cmd.ins_write || cmd.sh_write || cmd.dl_write;
   assign e_waddr = (cmd.sh_write || cmd.dl_write) ? base_ff + ADDR_W'(idx_ff)
                                                   : base_ff + ADDR_W'(pos_ff);
   assign e_wdata = (cmd.sh_write || cmd.dl_write) ? e_rdata : {col_ff, wval_ff};

   srms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .re    (e_re),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   // count RAM, swept to zero after reset
   assign c_we    = cmd.clr_step || cmd.ins_write || cmd.cnt_dec;
   assign c_re    = cmd.check;
   assign c_waddr = cmd.clr_step ? clr_idx_ff : row_addr;
   always_comb begin
      priority if (cmd.clr_step) c_wdata = '0;
      else if (cmd.ins_write)    c_wdata = cnt_up;
      else                       c_wdata = cnt_dn;
   end

   srms_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_ROWS)
   ) u_count_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .re    (c_re),
      .raddr (row_addr),
      .rdata (c_rdata)
   );

   always_comb begin
      status.clr_last     = (clr_idx_ff == ROW_W'(MAX_ROWS - 1));
      status.oor          = oor;
      status.is_write     = (op_ff == OP_WRITE);
      status.wval_zero    = (wval_ff == '0);
      status.found        = found_ff;
      status.col_less     = (rd_col < col_ff);
      status.col_equal    = (rd_col == col_ff);
      status.pos_at_count = (pos_ff == count_ff);
      status.row_full     = (count_ff == CNT_W'(MAX_COLUMNS));
      status.idx_at_pos   = (idx_ff == pos_ff);
      status.idx_last     = (idx_up == count_ff);
      status.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_found_ff};

endmodule

/* design/sparse_row_matrix_store_core.sv */
// Top level of the sparse row matrix store: per-row sorted (column, value) lists.
// A request is accepted in IDLE, then runs CHECK, COUNT, a SCAN_RD/SCAN_CMP pair per entry
// below the column, and POST; out of range it goes from CHECK straight to POST. POST waits
// while a held response word blocks. A write may then run UPDATE, a shift then INSERT, or
// a shift then DEC before the next accept; each shift step reads then writes the entry RAM.
// Reset: synchronous; the count RAM is swept to zero row by row, req_tready low.
module sparse_row_matrix_store_core #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [srms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srms_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_index[5:0], column_index[11:6], write_value[43:12], zero[47:44]
   input  logic [srms_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // operation[0]
   input  logic [srms_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value[31:0]
   output logic [srms_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // entry_found[0], status[1]
   output logic [srms_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   import srms_pkg::*;

   cmd_type    cmd;
   status_type status;

   srms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srms_dp #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

`include "sparse_row_matrix_store_core_assert.svh"

   // one word in flight at a time
   `SRMS_ASSERT_NEXT(a_single_word, clock, reset, req_tvalid && req_tready, !req_tready)
   // the output register is only loaded when it is empty or draining
   `SRMS_ASSERT_IMPLY(a_post_free, clock, reset, cmd.post, status.rsp_free)
   // an insert never grows a full row
   `SRMS_ASSERT_IMPLY(a_insert_room, clock, reset, cmd.ins_write, !status.row_full)

endmodule
